// ----- rtl/core/utc_pkg.sv -----
`default_nettype none

package utc_pkg;

  localparam int unsigned BASE_YEAR = 1970;
  // day of week of january 1 of the base year, 0 is sunday
  localparam int unsigned BASE_WEEKDAY = (1 + 5 * ((BASE_YEAR - 1) % 4)
                                           + 4 * ((BASE_YEAR - 1) % 100)
                                           + 6 * ((BASE_YEAR - 1) % 400)) % 7;

  localparam logic [31:0] DAY_SECS    = 32'd86400;
  localparam logic [31:0] HOUR_SECS   = 32'd3600;
  localparam logic [31:0] MIN_SECS    = 32'd60;
  localparam logic [31:0] WEEK_DAYS   = 32'd7;
  localparam logic [31:0] SUMMER_SECS = 32'd3600;

  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned CNT_W   = 4;

  // highest quotient bit of each restoring division
  localparam logic [CNT_W-1:0] DAY_TOP  = 4'd15;
  localparam logic [CNT_W-1:0] HOUR_TOP = 4'd4;
  localparam logic [CNT_W-1:0] MIN_TOP  = 4'd5;
  localparam logic [CNT_W-1:0] WDAY_TOP = 4'd13;

  localparam logic [6:0] BASE_MOD100 = 7'(BASE_YEAR % 100);
  localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % 400);

  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utc_seconds_to_calendar.sv -----
// channel   direction  handshake                  payload
// request   in         in_valid_i / in_stall_o    timestamp_seconds_i
// result    out        out_valid_o / out_stall_i  cal_year_o .. cal_weekday_o
// config    in         cfg_we_i                   cfg_wdata_i (summer time enable)
//
// the next request can be taken in the cycle after the result leaves. one
// compare-subtract unit runs 16 day-division steps, 5 hour steps, 6 minute
// steps, 14 weekday steps, one step per whole year and per whole month removed
// plus one closing step for each; an output stall holds the result in place.
// reset clears the summer time setting and the sequencer; no request is
// taken until the result of the previous one has left the output register.
`default_nettype none

module utc_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] timestamp_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      cal_year_o,
  output logic [3:0]       cal_month_o,
  output logic [4:0]       cal_day_o,
  output logic [4:0]       cal_hour_o,
  output logic [5:0]       cal_minute_o,
  output logic [5:0]       cal_second_o,
  output logic [2:0]       cal_weekday_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DAY, S_HOUR, S_MIN, S_WDAY, S_YEAR, S_MONTH, S_DONE
  } state_e;

  state_e state_q;
  logic   summer_q;

  logic [31:0]                   acc_q;
  logic [utc_pkg::CNT_W-1:0]     cnt_q;
  logic [utc_pkg::DAYS_W-1:0]    days_q;
  logic [utc_pkg::HOUR_W-1:0]    hour_q;
  logic [utc_pkg::MIN_W-1:0]     min_q;
  logic [utc_pkg::MIN_W-1:0]     sec_q;
  logic [utc_pkg::WDAY_W-1:0]    wday_q;
  logic [utc_pkg::YEAR_W-1:0]    year_q;
  logic [6:0]                    mod100_q;
  logic [8:0]                    mod400_q;
  logic [utc_pkg::MONTH_W-1:0]   month_q;

  logic        leap;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        ge;
  logic [31:0] diff;
  logic [31:0] acc_d;

  assign leap = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (year_q[1:0] == 2'b00));

  always_comb begin
    op_a = acc_q;
    op_b = '0;
    unique case (state_q)
      S_DAY:   op_b = utc_pkg::DAY_SECS << cnt_q;
      S_HOUR:  op_b = utc_pkg::HOUR_SECS << cnt_q;
      S_MIN:   op_b = utc_pkg::MIN_SECS << cnt_q;
      S_WDAY:  op_b = utc_pkg::WEEK_DAYS << cnt_q;
      S_YEAR: begin
        op_a = 32'(days_q);
        op_b = leap ? 32'd366 : 32'd365;
      end
      S_MONTH: begin
        op_a = 32'(days_q);
        op_b = 32'(utc_pkg::days_in_month(month_q, leap));
      end
      default: op_b = '0;
    endcase
  end

  utc_cmp_sub u_cmp_sub (
    .a_i    (op_a),
    .b_i    (op_b),
    .ge_o   (ge),
    .diff_o (diff)
  );

  assign acc_d = ge ? diff : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      summer_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        summer_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            acc_q   <= timestamp_seconds_i + (summer_q ? utc_pkg::SUMMER_SECS : 32'd0);
            cnt_q   <= utc_pkg::DAY_TOP;
            state_q <= S_DAY;
          end
        end
        S_DAY: begin
          acc_q  <= acc_d;
          days_q <= {days_q[utc_pkg::DAYS_W-2:0], ge};
          if (cnt_q == '0) begin
            cnt_q   <= utc_pkg::HOUR_TOP;
            state_q <= S_HOUR;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_HOUR: begin
          acc_q  <= acc_d;
          hour_q <= {hour_q[utc_pkg::HOUR_W-2:0], ge};
          if (cnt_q == '0) begin
            cnt_q   <= utc_pkg::MIN_TOP;
            state_q <= S_MIN;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_MIN: begin
          min_q <= {min_q[utc_pkg::MIN_W-2:0], ge};
          if (cnt_q == '0) begin
            sec_q   <= acc_d[utc_pkg::MIN_W-1:0];
            acc_q   <= 32'(days_q) + 32'(utc_pkg::BASE_WEEKDAY);
            cnt_q   <= utc_pkg::WDAY_TOP;
            state_q <= S_WDAY;
          end else begin
            acc_q <= acc_d;
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_WDAY: begin
          acc_q <= acc_d;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            wday_q   <= acc_d[utc_pkg::WDAY_W-1:0];
            year_q   <= 12'(utc_pkg::BASE_YEAR);
            mod100_q <= utc_pkg::BASE_MOD100;
            mod400_q <= utc_pkg::BASE_MOD400;
            state_q  <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (ge) begin
            days_q   <= diff[utc_pkg::DAYS_W-1:0];
            year_q   <= year_q + 12'd1;
            mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
            mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          end else begin
            month_q <= 4'd1;
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((month_q != utc_pkg::MONTH_LAST) && ge) begin
            days_q  <= diff[utc_pkg::DAYS_W-1:0];
            month_q <= month_q + 4'd1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_DONE);
  assign cal_year_o    = year_q;
  assign cal_month_o   = month_q;
  assign cal_day_o     = days_q[utc_pkg::DAY_W-1:0] + 5'd1;
  assign cal_hour_o    = hour_q;
  assign cal_minute_o  = min_q;
  assign cal_second_o  = sec_q;
  assign cal_weekday_o = wday_q;

endmodule

`default_nettype wire

// ----- rtl/core/utc_cmp_sub.sv -----
`default_nettype none

module utc_cmp_sub (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             ge_o,
  output logic      [31:0] diff_o
);

  logic [32:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~full[32];
  assign diff_o = full[31:0];

endmodule

`default_nettype wire

// ----- sim/calendar_checker.sv -----
module calendar_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [31:0]                  timestamp_seconds_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [utc_pkg::YEAR_W-1:0]   cal_year_i,
  input  logic [utc_pkg::MONTH_W-1:0]  cal_month_i,
  input  logic [utc_pkg::DAY_W-1:0]    cal_day_i,
  input  logic [utc_pkg::HOUR_W-1:0]   cal_hour_i,
  input  logic [utc_pkg::MIN_W-1:0]    cal_minute_i,
  input  logic [utc_pkg::MIN_W-1:0]    cal_second_i,
  input  logic [utc_pkg::WDAY_W-1:0]   cal_weekday_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [utc_pkg::YEAR_W-1:0]  year;
    logic [utc_pkg::MONTH_W-1:0] month;
    logic [utc_pkg::DAY_W-1:0]   day;
    logic [utc_pkg::HOUR_W-1:0]  hour;
    logic [utc_pkg::MIN_W-1:0]   minute;
    logic [utc_pkg::MIN_W-1:0]   second;
    logic [utc_pkg::WDAY_W-1:0]  weekday;
  } cal_t;

  cal_t expected_dates_q[$];
  logic summer_time_shadow;

  function automatic int unsigned leap_year(input int unsigned y);
    if (y % 400 == 0) return 1;
    if (y % 100 == 0) return 0;
    return (y % 4 == 0) ? 1 : 0;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:          return 28 + leap_year(y);
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic cal_t to_calendar(input logic [31:0] stamp, input logic summer);
    logic [31:0] t;
    int unsigned sod, days, y, m, len;
    int cc, yc, mc, w;
    cal_t c;
    t = stamp + (summer ? 32'd3600 : 32'd0);
    sod = t % 86400;
    days = t / 86400;
    y = utc_pkg::BASE_YEAR;
    while (days > 0) begin
      len = 365 + leap_year(y);
      if (days < len) break;
      days -= len;
      y++;
    end
    m = 1;
    while (m < 12) begin
      len = month_length(m, y);
      if (days < len) break;
      days -= len;
      m++;
    end
    // zeller with sunday as 0, remainder kept non-negative
    if (m <= 2) begin
      cc = int'((y - 1) / 100);
      yc = int'((y - 1) % 100);
      mc = int'(m) + 12;
    end else begin
      cc = int'(y / 100);
      yc = int'(y % 100);
      mc = int'(m);
    end
    w = yc + yc / 4 + cc / 4 - 2 * cc + (26 * (mc + 1)) / 10 + int'(days + 1) - 1;
    w = w % 7;
    if (w < 0) w += 7;
    c.year    = y[utc_pkg::YEAR_W-1:0];
    c.month   = m[utc_pkg::MONTH_W-1:0];
    c.day     = 5'(days + 1);
    c.hour    = 5'(sod / 3600);
    c.minute  = 6'((sod % 3600) / 60);
    c.second  = 6'(sod % 60);
    c.weekday = 3'(w);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, seen);
      fail_count_o++;
    end
  endtask

  always @(negedge clk_i) begin : watch
    cal_t seen, want;
    if (!rst_ni) begin
      expected_dates_q.delete();
      summer_time_shadow = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_dates_q.push_back(to_calendar(timestamp_seconds_i, summer_time_shadow));
      if (cfg_we_i) summer_time_shadow = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        seen = '{cal_year_i, cal_month_i, cal_day_i, cal_hour_i, cal_minute_i, cal_second_i,
                 cal_weekday_i};
        if (expected_dates_q.size() == 0) begin
          $display("%0t: unexpected date, expected none got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                   $time, seen.year, seen.month, seen.day, seen.hour, seen.minute,
                   seen.second, seen.weekday);
          fail_count_o++;
        end else begin
          want = expected_dates_q.pop_front();
          check_field("year", want.year, seen.year);
          check_field("month", want.month, seen.month);
          check_field("day", want.day, seen.day);
          check_field("hour", want.hour, seen.hour);
          check_field("minute", want.minute, seen.minute);
          check_field("second", want.second, seen.second);
          check_field("weekday", want.weekday, seen.weekday);
        end
      end
    end
    pending_o = expected_dates_q.size();
  end

endmodule

// ----- sim/utc_seconds_to_calendar_tb.sv -----
module utc_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {PHASE_PLAIN, PHASE_LONG_HOLD, PHASE_DRAIN_MID} phase_kind_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        timestamp_seconds_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [11:0]        cal_year_o;
  logic [3:0]         cal_month_o;
  logic [4:0]         cal_day_o;
  logic [4:0]         cal_hour_o;
  logic [5:0]         cal_minute_o;
  logic [5:0]         cal_second_o;
  logic [2:0]         cal_weekday_o;

  int fail_count;
  int pending_dates;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  utc_seconds_to_calendar uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .timestamp_seconds_i (timestamp_seconds_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cal_year_o          (cal_year_o),
    .cal_month_o         (cal_month_o),
    .cal_day_o           (cal_day_o),
    .cal_hour_o          (cal_hour_o),
    .cal_minute_o        (cal_minute_o),
    .cal_second_o        (cal_second_o),
    .cal_weekday_o       (cal_weekday_o)
  );

  calendar_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .timestamp_seconds_i (timestamp_seconds_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cal_year_i          (cal_year_o),
    .cal_month_i         (cal_month_o),
    .cal_day_i           (cal_day_o),
    .cal_hour_i          (cal_hour_o),
    .cal_minute_i        (cal_minute_o),
    .cal_second_i        (cal_second_o),
    .cal_weekday_i       (cal_weekday_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending_dates)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random stall plus an occasional long hold
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic longint unsigned year_start(input int unsigned y);
    longint unsigned s;
    s = 0;
    for (int unsigned yy = utc_pkg::BASE_YEAR; yy < y; yy++)
      s += (((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0)) ? 366 * 86400 : 365 * 86400;
    return s;
  endfunction

  function automatic logic [31:0] pick_stamp();
    longint unsigned s;
    int unsigned y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4: begin
        y = $urandom_range(1971, 2106);
        s = year_start(y) + $urandom_range(0, 172800) - 86400;
      end
      5: begin
        y = $urandom_range(1970, 2105);
        s = year_start(y) + 58 * 86400 + $urandom_range(0, 172799);
      end
      6: s = 32'hFFFF_F000 + $urandom_range(0, 4095);
      7: s = $urandom_range(0, 1000000);
      8: s = longint'($urandom_range(0, 49710)) * 86400 + $urandom_range(0, 2) - 1;
      default: begin
        s = 64'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) s = ~s;
      end
    endcase
    return s[31:0];
  endfunction

  task automatic send_request(input logic [31:0] stamp);
    int gap;
    logic taken;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    timestamp_seconds_i <= stamp;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_dates == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_summer_time(input logic enable);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
      default:       begin sender_idle_pct = 34; receiver_stall_pct = 34; end
    endcase
  endtask

  task automatic run_random(input idle_mode_e mode, input logic enable, input int count,
                            input phase_kind_e kind);
    write_summer_time(enable);
    set_idling(mode);
    if (kind == PHASE_LONG_HOLD) hold_requests++;
    for (int i = 0; i < count; i++) begin
      if (kind == PHASE_DRAIN_MID && i == count / 2) drain();
      send_request(pick_stamp());
    end
  endtask

  logic [31:0] plain_stamps[] = '{
    32'd0, 32'd59, 32'd86399, 32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
    32'd946684800, 32'd951782400, 32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
  };
  logic [31:0] summer_stamps[] = '{
    32'hFFFF_F1EF, 32'hFFFF_F1F0, 32'hFFFF_FFFF, 32'd31532400, 32'd0, 32'd82800
  };

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i <= 1'b0;
    timestamp_seconds_i <= '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_requests = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_summer_time(1'b0);
    foreach (plain_stamps[i]) send_request(plain_stamps[i]);
    write_summer_time(1'b1);
    foreach (summer_stamps[i]) send_request(summer_stamps[i]);

    run_random(IDLE_NONE,     1'b0, 80, PHASE_LONG_HOLD);
    run_random(IDLE_SENDER,   1'b1, 70, PHASE_PLAIN);
    run_random(IDLE_RECEIVER, 1'b0, 70, PHASE_DRAIN_MID);
    run_random(IDLE_BOTH,     1'b1, 70, PHASE_PLAIN);
    run_random(IDLE_NONE,     1'b1, 70, PHASE_PLAIN);
    run_random(IDLE_RECEIVER, 1'b1, 70, PHASE_LONG_HOLD);
    run_random(IDLE_BOTH,     1'b0, 70, PHASE_PLAIN);

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_dates == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
